@@ src/jsu_pkg.sv @@
// Shared types, character codes and helper functions for the JSON string unescaper.
package jsu_pkg;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_ESC    = 3'd1,
    MODE_HEX0   = 3'd2,
    MODE_HEX1   = 3'd3,
    MODE_HEX2   = 3'd4,
    MODE_HEX3   = 3'd5,
    MODE_FAILED = 3'd6
  } mode_t;

  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_B         = 8'h62;
  localparam logic [7:0] CH_F         = 8'h66;
  localparam logic [7:0] CH_N         = 8'h6E;
  localparam logic [7:0] CH_R         = 8'h72;
  localparam logic [7:0] CH_T         = 8'h74;
  localparam logic [7:0] CH_U         = 8'h75;

  localparam logic [7:0] CTL_BS  = 8'h08;
  localparam logic [7:0] CTL_FF  = 8'h0C;
  localparam logic [7:0] CTL_LF  = 8'h0A;
  localparam logic [7:0] CTL_CR  = 8'h0D;
  localparam logic [7:0] CTL_TAB = 8'h09;

  localparam logic [15:0] CP_MAX1 = 16'h007F;
  localparam logic [15:0] CP_MAX2 = 16'h07FF;
  localparam logic [7:0]  UTF8_LEAD2 = 8'hC0;
  localparam logic [7:0]  UTF8_LEAD3 = 8'hE0;
  localparam logic [7:0]  UTF8_CONT  = 8'h80;

  // one queued command: up to three bytes, or an error word
  typedef struct packed {
    logic [1:0]      count;   // 1..3
    logic [7:0]      b0;
    logic [7:0]      b1;
    logic [7:0]      b2;
    logic            failed;
    logic            fin;
  } cmd_t;

  typedef struct packed {
    logic       bad;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_digit(input logic [7:0] c);
    hex_t h;
    h.bad   = 1'b0;
    h.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.value = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.value = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.value = 4'(c - 8'h37);
    end else begin
      h.bad = 1'b1;
    end
    return h;
  endfunction

  function automatic cmd_t utf8_encode(input logic [15:0] cp);
    cmd_t e;
    e = '0;
    if (cp <= CP_MAX1) begin
      e.count = 2'd1;
      e.b0    = cp[7:0];
    end else if (cp <= CP_MAX2) begin
      e.count = 2'd2;
      e.b0    = UTF8_LEAD2 | {3'b000, cp[10:6]};
      e.b1    = UTF8_CONT | {2'b00, cp[5:0]};
    end else begin
      e.count = 2'd3;
      e.b0    = UTF8_LEAD3 | {4'b0000, cp[15:12]};
      e.b1    = UTF8_CONT | {2'b00, cp[11:6]};
      e.b2    = UTF8_CONT | {2'b00, cp[5:0]};
    end
    return e;
  endfunction

endpackage

@@ src/json_string_unescape_utf8.sv @@
// JSON string unescaper with UTF-8 output: top level.
// Each completed command is registered into the command queue; its result words appear at the queue head.
// Throughput: one input byte per cycle while full is low; results leave one per cycle
// while pop is held and empty is low; a \u escape is queued once its last hex digit arrives.
// full rises when the command queue holds FIFO_DEPTH entries not yet fully emitted.
// Synchronous rst clears decoder mode, hex accumulator, queue pointers and byte index.
module json_string_unescape_utf8 #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] char_in,
  input  logic       final_char,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] byte_out,
  output logic       failed,
  output logic       run_end,
  output logic       string_end
);

  jsu_pkg::cmd_t cmd, head;
  logic          cmd_valid;
  logic          head_empty;
  logic          head_done;
  logic          accept;

  assign accept = push && !full;

  jsu_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .char_in    (char_in),
    .final_char (final_char),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd)
  );

  jsu_cmd_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr      (cmd_valid),
    .wr_data (cmd),
    .rd      (head_done),
    .rd_data (head),
    .full    (full),
    .empty   (head_empty)
  );

  jsu_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_empty (head_empty),
    .pop        (pop),
    .head_done  (head_done),
    .empty      (empty),
    .byte_out   (byte_out),
    .failed     (failed),
    .run_end    (run_end),
    .string_end (string_end)
  );

endmodule

@@ src/jsu_front.sv @@
// Front end: escape decoder state machine, turns accepted bytes into commands.
module jsu_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [7:0]         char_in,
  input  logic               final_char,
  output logic               cmd_valid,
  output jsu_pkg::cmd_t      cmd
);

  jsu_pkg::mode_t mode, mode_next;
  logic [15:0]    accum, accum_next;
  jsu_pkg::hex_t  hx;
  logic           fail;
  logic [15:0]    cp;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= jsu_pkg::MODE_NORMAL;
      accum <= '0;
    end else if (accept) begin
      mode  <= mode_next;
      accum <= accum_next;
    end
  end

  always_comb begin
    hx         = jsu_pkg::hex_digit(char_in);
    cp         = {accum[11:0], hx.value};
    mode_next  = mode;
    accum_next = accum;
    fail       = 1'b0;
    cmd        = '0;
    unique case (mode) inside
      jsu_pkg::MODE_NORMAL: begin
        if (char_in == jsu_pkg::CH_BACKSLASH && !final_char) begin
          mode_next = jsu_pkg::MODE_ESC;
        end else begin
          cmd.count = 2'd1;
          cmd.b0    = char_in;
        end
      end
      jsu_pkg::MODE_ESC: begin
        mode_next = jsu_pkg::MODE_NORMAL;
        cmd.count = 2'd1;
        case (char_in)
          jsu_pkg::CH_QUOTE:     cmd.b0 = jsu_pkg::CH_QUOTE;
          jsu_pkg::CH_BACKSLASH: cmd.b0 = jsu_pkg::CH_BACKSLASH;
          jsu_pkg::CH_SLASH:     cmd.b0 = jsu_pkg::CH_SLASH;
          jsu_pkg::CH_B:         cmd.b0 = jsu_pkg::CTL_BS;
          jsu_pkg::CH_F:         cmd.b0 = jsu_pkg::CTL_FF;
          jsu_pkg::CH_N:         cmd.b0 = jsu_pkg::CTL_LF;
          jsu_pkg::CH_R:         cmd.b0 = jsu_pkg::CTL_CR;
          jsu_pkg::CH_T:         cmd.b0 = jsu_pkg::CTL_TAB;
          jsu_pkg::CH_U: begin
            cmd.count  = 2'd0;
            fail       = final_char;
            mode_next  = jsu_pkg::MODE_HEX0;
            accum_next = '0;
          end
          default: begin
            cmd.count = 2'd0;
            fail      = 1'b1;
          end
        endcase
      end
      jsu_pkg::MODE_HEX0, jsu_pkg::MODE_HEX1, jsu_pkg::MODE_HEX2: begin
        if (hx.bad) begin
          fail = 1'b1;
        end else begin
          accum_next = cp;
          mode_next  = jsu_pkg::mode_t'(mode + 3'd1);
          fail       = final_char;
        end
      end
      jsu_pkg::MODE_HEX3: begin
        if (hx.bad) begin
          fail = 1'b1;
        end else begin
          cmd        = jsu_pkg::utf8_encode(cp);
          accum_next = '0;
          mode_next  = jsu_pkg::MODE_NORMAL;
        end
      end
      default: fail = 1'b1;   // failed, or the unused code
    endcase

    if (fail) begin
      accum_next = '0;
      cmd        = '0;
      if (final_char) begin
        mode_next  = jsu_pkg::MODE_NORMAL;
        cmd.count  = 2'd1;
        cmd.failed = 1'b1;
      end else begin
        mode_next = jsu_pkg::MODE_FAILED;
      end
    end else if (final_char) begin
      mode_next  = jsu_pkg::MODE_NORMAL;
      accum_next = '0;
    end
    cmd.fin   = final_char;
    cmd_valid = accept && (cmd.count != 2'd0);
  end

endmodule

@@ src/jsu_cmd_fifo.sv @@
// Small register queue of commands between the decoder and the byte emitter.
module jsu_cmd_fifo #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr,
  input  jsu_pkg::cmd_t  wr_data,
  input  logic           rd,
  output jsu_pkg::cmd_t  rd_data,
  output logic           full,
  output logic           empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  jsu_pkg::cmd_t mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_wr, do_rd;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + PW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + PW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

@@ src/jsu_back.sv @@
// Back end: walks the bytes of the head command, one result word per pop.
module jsu_back (
  input  logic           clk,
  input  logic           rst,
  input  jsu_pkg::cmd_t  head,
  input  logic           head_empty,
  input  logic           pop,
  output logic           head_done,
  output logic           empty,
  output logic [7:0]     byte_out,
  output logic           failed,
  output logic           run_end,
  output logic           string_end
);

  logic [1:0] idx;
  logic       last;
  logic       take;

  assign empty      = head_empty;
  assign last       = (idx == head.count - 2'd1);
  assign take       = pop && !head_empty;
  assign head_done  = take && last;
  assign failed     = head.failed;
  assign run_end    = last;
  assign string_end = last && head.fin;

  always_comb begin
    case (idx)
      2'd0:    byte_out = head.b0;
      2'd1:    byte_out = head.b1;
      2'd2:    byte_out = head.b2;
      default: byte_out = head.b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (take) begin
      idx <= last ? 2'd0 : idx + 2'd1;
    end
  end

endmodule
